// ----- src/life_generation_row_stepper_defines.svh -----
// assertion macros for the row stepper checker
`ifndef LIFE_GENERATION_ROW_STEPPER_DEFINES_SVH
`define LIFE_GENERATION_ROW_STEPPER_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define LGRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define LGRS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/lgrs_pkg.sv -----
package lgrs_pkg;

   localparam int GRID_WIDTH_DEFAULT = 64;
   localparam int CFG_WIDTH = 7;
   localparam logic [CFG_WIDTH-1:0] ACTIVE_WIDTH_RESET = 7'd64;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_ADDR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);
   // worst case words one row pushes
   localparam int ROW_MAX_WORDS = 2;

   // b3/s23 rule
   localparam int NEIGHBOR_COUNT_WIDTH = 4;
   localparam logic [NEIGHBOR_COUNT_WIDTH-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [NEIGHBOR_COUNT_WIDTH-1:0] SURVIVE_COUNT = 4'd2;

   typedef struct packed {
      logic first_valid;
      logic second_valid;
   } push_type;

endpackage

// ----- src/lgrs_channels.sv -----
interface lgrs_req_if import lgrs_pkg::*; #(
   parameter int WIDTH = GRID_WIDTH_DEFAULT
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] row_cells;
   logic             last_row;

   modport source (output valid, output row_cells, output last_row, input ready);
   modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

interface lgrs_rsp_if import lgrs_pkg::*; #(
   parameter int WIDTH = GRID_WIDTH_DEFAULT
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] next_cells;
   logic [WIDTH-1:0] changed_cells;
   logic             last_out;

   modport source (output valid, output next_cells, output changed_cells, output last_out,
                   input ready);
   modport sink   (input valid, input next_cells, input changed_cells, input last_out,
                   output ready);
endinterface

// ----- src/lgrs_evolve.sv -----
module lgrs_evolve import lgrs_pkg::*; #(
   parameter int WIDTH = GRID_WIDTH_DEFAULT
) (
   input  logic [WIDTH-1:0]     above,
   input  logic [WIDTH-1:0]     mid,
   input  logic [WIDTH-1:0]     below,
   input  logic [CFG_WIDTH-1:0] eff_width,
   output logic [WIDTH-1:0]     next_cells
);

   for (genvar i = 0; i < WIDTH; i++) begin : g_col
      if (i == 0 || i == WIDTH - 1) begin : g_border
         assign next_cells[i] = 1'b0;
      end else begin : g_inner
         logic [NEIGHBOR_COUNT_WIDTH-1:0] count;
         logic                            interior;

         assign count = NEIGHBOR_COUNT_WIDTH'(above[i-1]) + NEIGHBOR_COUNT_WIDTH'(above[i])
                      + NEIGHBOR_COUNT_WIDTH'(above[i+1]) + NEIGHBOR_COUNT_WIDTH'(mid[i-1])
                      + NEIGHBOR_COUNT_WIDTH'(mid[i+1]) + NEIGHBOR_COUNT_WIDTH'(below[i-1])
                      + NEIGHBOR_COUNT_WIDTH'(below[i]) + NEIGHBOR_COUNT_WIDTH'(below[i+1]);
         // right neighbor must still be an active column
         assign interior = (CFG_WIDTH'(i + 1) < eff_width);
         assign next_cells[i] = interior &&
                                (count == BIRTH_COUNT || (mid[i] && count == SURVIVE_COUNT));
      end
   end

endmodule

// ----- src/lgrs_result_fifo.sv -----
module lgrs_result_fifo import lgrs_pkg::*; #(
   parameter int DATA_WIDTH = 2 * GRID_WIDTH_DEFAULT + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  push_type                    push,
   input  logic [DATA_WIDTH-1:0]       first_data,
   input  logic [DATA_WIDTH-1:0]       second_data,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output logic [DATA_WIDTH-1:0]       pop_data,
   output logic [FIFO_COUNT_WIDTH-1:0] fill_count
);

   logic [DATA_WIDTH-1:0]       mem [FIFO_DEPTH];
   logic [FIFO_ADDR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_ADDR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [FIFO_ADDR_WIDTH-1:0]  second_addr;
   logic                        pop;

   assign pop_valid   = (count_ff != '0);
   assign pop         = pop_valid && pop_ready;
   assign pop_data    = mem[rd_ptr_ff];
   assign fill_count  = count_ff;
   assign second_addr = wr_ptr_ff + FIFO_ADDR_WIDTH'(push.first_valid);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_ADDR_WIDTH'(push.first_valid)
                + FIFO_ADDR_WIDTH'(push.second_valid);
      rd_ptr_in = rd_ptr_ff + FIFO_ADDR_WIDTH'(pop);
      count_in  = count_ff + FIFO_COUNT_WIDTH'(push.first_valid)
                + FIFO_COUNT_WIDTH'(push.second_valid) - FIFO_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem[wr_ptr_ff] <= first_data;
      end
      if (push.second_valid) begin
         mem[second_addr] <= second_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/life_generation_row_stepper.sv -----
// a row's word enters the result queue once the row below it is in the input register;
//    the bottom row's own word follows right behind, so a grid of n rows gives n words
// throughput: one row word per cycle while the 8-entry queue has room (a row may push two)
// reset: synchronous, active high; clears the row history, the queue and sets active width 64
module life_generation_row_stepper import lgrs_pkg::*; #(
   parameter int GRID_WIDTH = GRID_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   lgrs_req_if.sink             req_chan,
   lgrs_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CFG_WIDTH-1:0] csr_write_data
);

   localparam int RSP_WIDTH = 2 * GRID_WIDTH + 1;
   localparam int SUM_WIDTH = FIFO_COUNT_WIDTH + 1;
   localparam logic [1:0] ROWS_FULL = 2'd2;

   // configuration
   logic [CFG_WIDTH-1:0] active_width_ff;
   logic [CFG_WIDTH-1:0] eff_width;
   logic [GRID_WIDTH-1:0] width_mask;

   // input register
   logic                  in_valid_ff;
   logic [GRID_WIDTH-1:0] row_ff;
   logic                  last_ff;
   logic                  req_accept;

   // row history
   logic [GRID_WIDTH-1:0] upper_ff, upper_in;
   logic [GRID_WIDTH-1:0] middle_ff, middle_in;
   logic [1:0]            rows_seen_ff, rows_seen_in;

   // compute stage
   logic [GRID_WIDTH-1:0] row_masked;
   logic [GRID_WIDTH-1:0] evolved;
   logic [GRID_WIDTH-1:0] first_next;
   push_type              push;
   logic [RSP_WIDTH-1:0]  first_data;
   logic [RSP_WIDTH-1:0]  second_data;
   logic [RSP_WIDTH-1:0]  pop_data;
   logic [FIFO_COUNT_WIDTH-1:0] fill_count;
   logic [SUM_WIDTH-1:0]  reserved;

   // widths beyond the grid act as the grid width
   assign eff_width = (active_width_ff > CFG_WIDTH'(GRID_WIDTH)) ? CFG_WIDTH'(GRID_WIDTH)
                                                                 : active_width_ff;

   always_comb begin
      for (int i = 0; i < GRID_WIDTH; i++) begin
         width_mask[i] = (CFG_WIDTH'(i) < eff_width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff <= ACTIVE_WIDTH_RESET;
      end else if (csr_write_enable) begin
         active_width_ff <= csr_write_data;
      end
   end

   // queue space for what is already in the queue, the row in the input
   // register and the row being offered, two words each at worst
   assign reserved = SUM_WIDTH'(fill_count) + (in_valid_ff ? SUM_WIDTH'(ROW_MAX_WORDS) : '0);
   assign req_chan.ready = (reserved <= SUM_WIDTH'(FIFO_DEPTH - ROW_MAX_WORDS));
   assign req_accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_ff  <= req_chan.row_cells;
         last_ff <= req_chan.last_row;
      end
   end

   assign row_masked = row_ff & width_mask;

   lgrs_evolve #(
      .WIDTH(GRID_WIDTH)
   ) u_evolve (
      .above     (upper_ff),
      .mid       (middle_ff),
      .below     (row_masked),
      .eff_width (eff_width),
      .next_cells(evolved)
   );

   // the top row of a grid has no row above, so it dies
   assign first_next = (rows_seen_ff == ROWS_FULL) ? evolved : '0;

   // first word finishes the middle row, second word is the bottom row itself
   assign push.first_valid  = in_valid_ff && (rows_seen_ff != 2'd0);
   assign push.second_valid = in_valid_ff && last_ff;
   assign first_data  = {first_next & width_mask, (first_next ^ middle_ff) & width_mask, 1'b0};
   assign second_data = {{GRID_WIDTH{1'b0}}, row_masked, 1'b1};

   // history shifts down one row, and clears after the bottom row
   always_comb begin
      upper_in     = upper_ff;
      middle_in    = middle_ff;
      rows_seen_in = rows_seen_ff;
      if (in_valid_ff) begin
         if (last_ff) begin
            upper_in     = '0;
            middle_in    = '0;
            rows_seen_in = 2'd0;
         end else begin
            upper_in  = middle_ff;
            middle_in = row_masked;
            if (rows_seen_ff != ROWS_FULL) begin
               rows_seen_in = rows_seen_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= '0;
         middle_ff    <= '0;
         rows_seen_ff <= 2'd0;
      end else begin
         upper_ff     <= upper_in;
         middle_ff    <= middle_in;
         rows_seen_ff <= rows_seen_in;
      end
   end

   lgrs_result_fifo #(
      .DATA_WIDTH(RSP_WIDTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .first_data (first_data),
      .second_data(second_data),
      .pop_valid  (rsp_chan.valid),
      .pop_ready  (rsp_chan.ready),
      .pop_data   (pop_data),
      .fill_count (fill_count)
   );

   // unpack the queued word
   assign rsp_chan.next_cells    = pop_data[RSP_WIDTH-1 -: GRID_WIDTH];
   assign rsp_chan.changed_cells = pop_data[GRID_WIDTH:1];
   assign rsp_chan.last_out      = pop_data[0];

endmodule

// ----- src/lgrs_checker.sv -----
`include "life_generation_row_stepper_defines.svh"

module lgrs_checker import lgrs_pkg::*; #(
   parameter int WIDTH = GRID_WIDTH_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [WIDTH-1:0] next_cells,
   input logic             last_out
);

   logic any_alive;
   logic border_alive;

   assign any_alive    = |next_cells;
   assign border_alive = next_cells[0] || next_cells[WIDTH-1];

   // a word offered must stay offered until taken
   `LGRS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")

   // nothing is offered right after reset
   `LGRS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // the bottom row has no row below, so it always dies
   `LGRS_ASSERT(a_last_dead, clock, reset, rsp_valid && last_out |-> !any_alive, "bottom alive")

   // border columns never live
   `LGRS_ASSERT(a_border_dead, clock, reset, rsp_valid |-> !border_alive, "border alive")

endmodule

bind life_generation_row_stepper lgrs_checker #(
   .WIDTH(GRID_WIDTH)
) u_lgrs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .next_cells(rsp_chan.next_cells),
   .last_out  (rsp_chan.last_out)
);

// ----- tb/lgrs_row_checker.sv -----
`timescale 1ns / 1ps

module lgrs_row_checker import lgrs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lgrs_req_if                  req_chan,
   lgrs_rsp_if                  rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CFG_WIDTH-1:0] csr_write_data,
   output int                   error_count,
   output int                   pending_count,
   output int                   rows_checked
);

   localparam int GW = GRID_WIDTH_DEFAULT;

   typedef logic [GW-1:0] row_type;

   typedef struct packed {
      row_type next_cells;
      row_type changed_cells;
      logic    last_out;
   } row_word_type;

   row_word_type         expected_words[$];
   logic [CFG_WIDTH-1:0] width_reg;
   row_type              above_row;
   row_type              center_row;
   int unsigned          rows_held;

   function automatic int unsigned live_width(logic [CFG_WIDTH-1:0] w);
      return (w > GW) ? GW : int'(w);
   endfunction

   function automatic row_type column_mask(int unsigned w);
      row_type m;
      m = '0;
      for (int i = 0; i < w; i++) m[i] = 1'b1;
      return m;
   endfunction

   // b3/s23 on interior columns only
   function automatic row_type next_generation(row_type above, row_type mid, row_type below,
                                               int unsigned w);
      row_type     nxt;
      int unsigned n;
      nxt = '0;
      for (int i = 1; i + 1 < w; i++) begin
         n = 0;
         for (int d = -1; d <= 1; d++) n += above[i+d] + below[i+d];
         n += mid[i-1] + mid[i+1];
         if (n == BIRTH_COUNT || (mid[i] && n == SURVIVE_COUNT)) nxt[i] = 1'b1;
      end
      return nxt;
   endfunction

   function automatic void predict_row(row_type cells_in, logic last_in);
      int unsigned w;
      row_type     mask;
      row_type     cells;
      row_type     nxt;
      w     = live_width(width_reg);
      mask  = column_mask(w);
      cells = cells_in & mask;
      if (rows_held != 0) begin
         nxt = (rows_held >= 2) ? next_generation(above_row, center_row, cells, w) : '0;
         expected_words.push_back('{next_cells: nxt & mask,
                                    changed_cells: (nxt ^ center_row) & mask,
                                    last_out: 1'b0});
      end
      if (last_in) begin
         // bottom row flushes with itself as a dead row
         expected_words.push_back('{next_cells: '0, changed_cells: cells, last_out: 1'b1});
         above_row  = '0;
         center_row = '0;
         rows_held  = 0;
      end else begin
         above_row  = center_row;
         center_row = cells;
         if (rows_held < 2) rows_held++;
      end
   endfunction

   always @(posedge clock) begin
      row_word_type exp_word;
      if (reset) begin
         expected_words.delete();
         width_reg    = ACTIVE_WIDTH_RESET;
         above_row    = '0;
         center_row   = '0;
         rows_held    = 0;
         error_count  = 0;
         rows_checked = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_row(req_chan.row_cells, req_chan.last_row);
         if (rsp_chan.valid && rsp_chan.ready) begin
            rows_checked++;
            if (expected_words.size() == 0) begin
               $error("unexpected word: next_cells %h changed_cells %h last_out %b",
                      rsp_chan.next_cells, rsp_chan.changed_cells, rsp_chan.last_out);
               error_count++;
            end else begin
               exp_word = expected_words.pop_front();
               if (rsp_chan.next_cells !== exp_word.next_cells) begin
                  $error("next_cells: expected %h, got %h",
                         exp_word.next_cells, rsp_chan.next_cells);
                  error_count++;
               end
               if (rsp_chan.changed_cells !== exp_word.changed_cells) begin
                  $error("changed_cells: expected %h, got %h",
                         exp_word.changed_cells, rsp_chan.changed_cells);
                  error_count++;
               end
               if (rsp_chan.last_out !== exp_word.last_out) begin
                  $error("last_out: expected %b, got %b",
                         exp_word.last_out, rsp_chan.last_out);
                  error_count++;
               end
            end
         end
         if (csr_write_enable) width_reg = csr_write_data;
      end
      pending_count = expected_words.size();
   end

endmodule

// ----- tb/tb_life_generation_row_stepper.sv -----
`timescale 1ns / 1ps

module tb_life_generation_row_stepper;
   import lgrs_pkg::*;

   localparam int          GW          = GRID_WIDTH_DEFAULT;
   localparam int          NUM_PHASES  = 13;
   localparam int          PHASE_ROWS  = 95;
   localparam int          DRAIN_WAIT  = 8;
   localparam longint      CYCLE_LIMIT = 400000;

   typedef logic [GW-1:0] row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CFG_WIDTH-1:0] csr_write_data;

   int                   error_count;
   int                   pending_count;
   int                   rows_checked;

   // stimulus bookkeeping
   int                   rows_sent;
   int                   grids_sent;
   int                   width_writes;
   longint               cycle_count;

   // idling knobs, percent chance per sent word (gap) or per ready stretch (stall)
   bit                   quiet;
   int unsigned          gap_pct;
   int unsigned          stall_pct;

   // width per phase; two slots get random values, the last phase runs without idling
   int unsigned phase_widths[NUM_PHASES] = '{64, 3, 4, 0, 1, 2, 127, 65, 10, 33, 0, 0, 64};

   lgrs_req_if #(.WIDTH(GW)) req_chan ();
   lgrs_rsp_if #(.WIDTH(GW)) rsp_chan ();

   life_generation_row_stepper #(.GRID_WIDTH(GW)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // watches both channels and the width writes, predicts and compares
   lgrs_row_checker row_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .rows_checked     (rows_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop if the block hangs
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending", cycle_count,
                  pending_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side back-pressure: random stall bursts, or ready stretches
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   // mix of densities so births, survivals and deaths all show up
   function automatic row_type random_row();
      row_type a;
      row_type b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2, 3:    return a & b & {$urandom, $urandom};
         4, 5:    return a & b;
         6:       return a | b;
         default: return a;
      endcase
   endfunction

   // one row word, with an optional sender gap first; returns at the falling edge
   // after the accept so the next word can follow without a bubble
   task automatic send_row(row_type cells, logic last);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.row_cells <= cells;
      req_chan.last_row  <= last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      rows_sent++;
      if (last) grids_sent++;
   endtask

   // random grid, with the odd repeated row so still lifes and stripes appear
   task automatic send_grid(int unsigned n_rows);
      row_type prev;
      row_type cells;
      prev = '0;
      for (int unsigned i = 0; i < n_rows; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0) cells = prev;
         else cells = random_row();
         send_row(cells, i == n_rows - 1);
         prev = cells;
      end
   endtask

   // all words in, then a drain wait of DRAIN_WAIT for anything still in flight
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_width(logic [CFG_WIDTH-1:0] w);
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      width_writes++;
   endtask

   initial begin
      int unsigned w;
      int unsigned n;
      int unsigned phase_rows;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.row_cells = '0;
      req_chan.last_row  = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      quiet              = 1'b0;
      gap_pct            = 25;
      stall_pct          = 25;
      rows_sent          = 0;
      grids_sent         = 0;
      width_writes       = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed grids at the reset width of 64
      // single-row grid: top and bottom at once, all cells die
      send_row('1, 1'b1);
      // solid block: every interior cell has eight live neighbors, so all cells die
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);
      // vertical blinker in column 5, turns horizontal in the middle row
      send_row('0, 1'b0);
      send_row(row_type'(1) << 5, 1'b0);
      send_row(row_type'(1) << 5, 1'b0);
      send_row(row_type'(1) << 5, 1'b0);
      send_row('0, 1'b1);
      // live cells on both border columns, which count as neighbors but never live
      send_row({2'b11, {(GW-4){1'b0}}, 2'b11}, 1'b0);
      send_row({2'b11, {(GW-4){1'b0}}, 2'b11}, 1'b0);
      send_row({2'b11, {(GW-4){1'b0}}, 2'b11}, 1'b0);
      send_row({2'b11, {(GW-4){1'b0}}, 2'b11}, 1'b1);
      // two-row grid: no interior row at all
      send_row(random_row(), 1'b0);
      send_row(random_row(), 1'b1);
      // empty grid
      send_row('0, 1'b0);
      send_row('0, 1'b0);
      send_row('0, 1'b1);
      // glider against the top columns
      send_row('0, 1'b0);
      send_row(row_type'(64'h2) << 60, 1'b0);
      send_row(row_type'(64'h4) << 60, 1'b0);
      send_row(row_type'(64'h7) << 60, 1'b0);
      send_row('0, 1'b1);

      // random phases, one width each, including the narrow and the oversized ones
      for (int p = 0; p < NUM_PHASES; p++) begin
         w = phase_widths[p];
         if (p == 10) w = $urandom_range(3, 64);
         if (p == 11) w = $urandom_range(0, 127);
         wait_drained();
         quiet = (p == NUM_PHASES - 1);
         case ($urandom_range(0, 2))
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 10; stall_pct = 15; end
            default: begin gap_pct = 40; stall_pct = 45; end
         endcase
         write_width(CFG_WIDTH'(w));
         phase_rows = 0;
         while (phase_rows < PHASE_ROWS) begin
            case ($urandom_range(0, 9))
               0:       n = 1;
               1:       n = 2;
               default: n = $urandom_range(3, 16);
            endcase
            send_grid(n);
            phase_rows += n;
         end
      end

      wait_drained();
      $display("sent %0d rows in %0d grids over %0d width settings", rows_sent, grids_sent,
               width_writes + 1);
      $display("checked %0d row words against the prediction", rows_checked);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/lgrs_pkg.sv
src/lgrs_channels.sv
src/lgrs_evolve.sv
src/lgrs_result_fifo.sv
src/life_generation_row_stepper.sv
src/lgrs_checker.sv
tb/lgrs_row_checker.sv
tb/tb_life_generation_row_stepper.sv
